// ----- design/bog_pkg.sv -----
// Package for blob_object_grouping: payload structs, outcome codes, FSM states.
// No dependencies.
package bog_pkg;

  localparam int COLOR_TOL = 25;

  typedef enum logic [1:0] {
    OUT_MERGED  = 2'd0,
    OUT_CREATED = 2'd1,
    OUT_DROPPED = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_POSITION_RATE   = 2'd0,
    CFG_COLOR_RATE      = 2'd1,
    CFG_POINT_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_WAIT,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic               start_frame;
    logic [7:0]         blob_ch0;
    logic [7:0]         blob_ch1;
    logic [7:0]         blob_ch2;
    logic [10:0]        blob_lower_x;
    logic [10:0]        blob_lower_y;
    logic [10:0]        blob_upper_x;
    logic [10:0]        blob_upper_y;
    logic signed [11:0] blob_vel_x;
    logic signed [11:0] blob_vel_y;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         object_slot;
    logic [1:0]         outcome;
    logic [7:0]         obj_ch0;
    logic [7:0]         obj_ch1;
    logic [7:0]         obj_ch2;
    logic [10:0]        obj_lower_x;
    logic [10:0]        obj_lower_y;
    logic [10:0]        obj_upper_x;
    logic [10:0]        obj_upper_y;
    logic signed [11:0] obj_vel_x;
    logic signed [11:0] obj_vel_y;
  } out_beat_t;

endpackage

// ----- design/blob_object_grouping.sv -----
// Blob-to-object grouping table: first-match scan over an object memory.
// Each stored object is read and then checked in turn; a merge runs five divider
// passes (three colour and two velocity averages) before the write.
// Throughput: one blob at a time; the next beat is taken the cycle after the
// result loads, and a stalled result holds the block in its write state.
// Reset clears object count, state, output valid and config registers; memory contents are not cleared.
module blob_object_grouping #(
  parameter int MAX_OBJECTS = 64,
  parameter int COORD_MAX   = 2047
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bog_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bog_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);
  import bog_pkg::*;

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  typedef struct packed {
    logic [7:0]         c0, c1, c2;
    logic [10:0]        lx, ly, ux, uy;
    logic signed [11:0] vx, vy;
  } ent_t;

  ent_t mem [MAX_OBJECTS];
  ent_t rd_r, blob_r, res_r;
  logic         we;
  logic [AW-1:0] addr;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic [4:0]  prate_r, crate_r;
  logic [10:0] thr_r;
  logic [2:0]  lane_r;
  out_beat_t   out_r;
  logic        ov_r;
  logic [1:0]  oc_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= res_r;
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prate_r <= 5'd3;
      crate_r <= 5'd9;
      thr_r   <= 11'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POSITION_RATE:   prate_r <= cfg_data[4:0];
        CFG_COLOR_RATE:      crate_r <= cfg_data[4:0];
        CFG_POINT_THRESHOLD: thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [10:0] sat(input logic [10:0] v);
    return (32'(v) > COORD_MAX) ? 11'(COORD_MAX) : v;
  endfunction
  function automatic logic [11:0] ad(input logic [11:0] a, input logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic col_ok, lo_far, up_far, match;
  always_comb begin
    col_ok = ad({4'd0, rd_r.c0}, {4'd0, blob_r.c0}) <= 12'(COLOR_TOL) &&
             ad({4'd0, rd_r.c1}, {4'd0, blob_r.c1}) <= 12'(COLOR_TOL) &&
             ad({4'd0, rd_r.c2}, {4'd0, blob_r.c2}) <= 12'(COLOR_TOL);
    lo_far = ad({1'b0, rd_r.lx}, {1'b0, blob_r.lx}) > {1'b0, thr_r} &&
             ad({1'b0, rd_r.ly}, {1'b0, blob_r.ly}) > {1'b0, thr_r};
    up_far = ad({1'b0, rd_r.ux}, {1'b0, blob_r.ux}) > {1'b0, thr_r} &&
             ad({1'b0, rd_r.uy}, {1'b0, blob_r.uy}) > {1'b0, thr_r};
    match  = col_ok && !lo_far && !up_far;
  end

  // divider shared over the five running averages, one lane at a time
  logic               dv_start, dv_done;
  logic signed [12:0] dv_num, dv_q;
  logic [4:0]         dv_rate;
  always_comb begin
    unique case (lane_r)
      3'd0: dv_num = 13'(signed'({1'b0, blob_r.c0})) - 13'(signed'({1'b0, res_r.c0}));
      3'd1: dv_num = 13'(signed'({1'b0, blob_r.c1})) - 13'(signed'({1'b0, res_r.c1}));
      3'd2: dv_num = 13'(signed'({1'b0, blob_r.c2})) - 13'(signed'({1'b0, res_r.c2}));
      3'd3: dv_num = 13'(blob_r.vx) - 13'(res_r.vx);
      default: dv_num = 13'(blob_r.vy) - 13'(res_r.vy);
    endcase
    dv_rate = (lane_r < 3'd3) ? crate_r : prate_r;
  end

  bog_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_num),
    .divisor(dv_rate), .done(dv_done), .quotient(dv_q)
  );

  logic accept;
  logic [CW-1:0] cnt_eff;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cnt_eff  = count_r;

  always_comb begin
    state_nxt = state_r;
    we        = 1'b0;
    addr      = idx_r;
    dv_start  = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ: begin
        if (CW'(idx_r) < cnt_eff) state_nxt = ST_CHECK;
        else state_nxt = ST_WRITE;
      end
      ST_CHECK: if (match) state_nxt = ST_DIV;
      else if (32'(idx_r) == MAX_OBJECTS - 1) state_nxt = ST_WRITE;
      else state_nxt = ST_READ;
      // start a lane once res_r and lane_r hold its operands
      ST_DIV: begin
        dv_start  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: if (dv_done) begin
        if (lane_r == 3'd4) state_nxt = ST_WRITE;
        else state_nxt = ST_DIV;
      end
      ST_WRITE: begin
        we = (oc_r != OUT_DROPPED);
        if (!ov_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_data.start_frame) count_r <= '0;
      if (state_r == ST_WRITE && state_nxt == ST_IDLE) begin
        ov_r <= 1'b1;
        if (oc_r == OUT_CREATED) count_r <= count_r + CW'(1);
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (accept) begin
        idx_r  <= '0;
        blob_r <= '{in_data.blob_ch0, in_data.blob_ch1, in_data.blob_ch2,
                    sat(in_data.blob_lower_x), sat(in_data.blob_lower_y),
                    sat(in_data.blob_upper_x), sat(in_data.blob_upper_y),
                    in_data.blob_vel_x, in_data.blob_vel_y};
      end
      ST_READ: if (!(CW'(idx_r) < cnt_eff)) begin
        // no match among stored objects: create or drop
        if (32'(count_r) < MAX_OBJECTS) begin
          oc_r  <= OUT_CREATED;
          res_r <= '{blob_r.c0, blob_r.c1, blob_r.c2, blob_r.lx, blob_r.ly,
                     blob_r.ux, blob_r.uy, 12'sd0, 12'sd0};
        end else begin
          oc_r  <= OUT_DROPPED;
          res_r <= '0;
        end
      end
      ST_CHECK: if (match) begin
        oc_r   <= OUT_MERGED;
        lane_r <= 3'd0;
        res_r  <= '{rd_r.c0, rd_r.c1, rd_r.c2,
                    (blob_r.lx < rd_r.lx) ? blob_r.lx : rd_r.lx,
                    (blob_r.ly < rd_r.ly) ? blob_r.ly : rd_r.ly,
                    (blob_r.ux > rd_r.ux) ? blob_r.ux : rd_r.ux,
                    (blob_r.uy > rd_r.uy) ? blob_r.uy : rd_r.uy,
                    rd_r.vx, rd_r.vy};
      end else if (32'(idx_r) == MAX_OBJECTS - 1) begin
        oc_r  <= OUT_DROPPED;
        res_r <= '0;
      end else idx_r <= idx_r + AW'(1);
      ST_WAIT: if (dv_done) begin
        lane_r <= lane_r + 3'd1;
        unique case (lane_r)
          3'd0: res_r.c0 <= res_r.c0 + dv_q[7:0];
          3'd1: res_r.c1 <= res_r.c1 + dv_q[7:0];
          3'd2: res_r.c2 <= res_r.c2 + dv_q[7:0];
          3'd3: res_r.vx <= res_r.vx + dv_q[11:0];
          default: res_r.vy <= res_r.vy + dv_q[11:0];
        endcase
      end
      ST_WRITE: if (state_nxt == ST_IDLE) begin
        out_r <= '{(oc_r == OUT_DROPPED) ? 6'd0 : 6'(idx_r), oc_r,
                   res_r.c0, res_r.c1, res_r.c2, res_r.lx, res_r.ly,
                   res_r.ux, res_r.uy, res_r.vx, res_r.vy};
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !accept) else $error("accept while busy");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_OBJECTS) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
endmodule

// ----- design/bog_div.sv -----
// Restoring divider for signed 13-bit difference by 5-bit rate, truncating.
// Depends on nothing; one quotient bit per cycle.
module bog_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [12:0] dividend,
  input  logic [4:0]         divisor,
  output logic               done,
  output logic signed [12:0] quotient
);
  logic [11:0] rem_r, rem_nxt;
  logic [12:0] q_r, q_nxt;
  logic [4:0]  dv_r;
  logic        neg_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic [12:0] mag;
  logic [12:0] trial;
  logic [12:0] part;

  assign mag = dividend[12] ? 13'(-dividend) : 13'(dividend);
  // next partial remainder
  assign part  = {rem_r, q_r[12]};
  assign trial = part - {8'd0, dv_r};

  always_comb begin
    if (!trial[12]) begin
      rem_nxt = trial[11:0];
      q_nxt   = {q_r[11:0], 1'b1};
    end else begin
      rem_nxt = part[11:0];
      q_nxt   = {q_r[11:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd12) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= mag;
      dv_r  <= (divisor == 5'd0) ? 5'd1 : divisor;
      neg_r <= dividend[12];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = !busy_r && !start;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// ----- tb/tb.sv -----
// Testbench for blob_object_grouping: random and directed blobs checked against
// a behavioral model of the object table. Depends on bog_pkg and the block.
`timescale 1ns / 100ps

module tb;
  import bog_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int NUM_RANDOM = 1476;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    int ch[3];
    int lo[2];
    int up[2];
    int vel[2];
  } obj_rec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [10:0] cfg_data;

  blob_object_grouping uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  obj_rec_t obj_table[NUM_SLOTS];
  int obj_count;
  int vel_rate, col_rate, corner_thresh;

  in_beat_t blob_queue[$];
  out_beat_t expected_q[$];
  int mismatches;
  int results_seen;
  int merges_seen, creates_seen, drops_seen;
  int idle_cycles;
  bit long_hold_req;
  bit driver_pause;
  bit in_took;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int absd(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic out_beat_t group_blob(in_beat_t b);
    obj_rec_t nb;
    out_beat_t r;
    int pr, cr;
    bit hit;
    if (b.start_frame) obj_count = 0;
    nb.ch[0] = b.blob_ch0; nb.ch[1] = b.blob_ch1; nb.ch[2] = b.blob_ch2;
    nb.lo[0] = b.blob_lower_x; nb.lo[1] = b.blob_lower_y;
    nb.up[0] = b.blob_upper_x; nb.up[1] = b.blob_upper_y;
    nb.vel[0] = int'(b.blob_vel_x); nb.vel[1] = int'(b.blob_vel_y);
    pr = vel_rate == 0 ? 1 : vel_rate;
    cr = col_rate == 0 ? 1 : col_rate;
    r = '0;
    for (int i = 0; i < obj_count; i++) begin
      hit = 1;
      for (int k = 0; k < 3; k++)
        if (absd(obj_table[i].ch[k], nb.ch[k]) > COLOR_TOL) hit = 0;
      if (absd(obj_table[i].lo[0], nb.lo[0]) > corner_thresh &&
          absd(obj_table[i].lo[1], nb.lo[1]) > corner_thresh) hit = 0;
      if (absd(obj_table[i].up[0], nb.up[0]) > corner_thresh &&
          absd(obj_table[i].up[1], nb.up[1]) > corner_thresh) hit = 0;
      if (hit) begin
        for (int k = 0; k < 2; k++) begin
          obj_table[i].vel[k] += (nb.vel[k] - obj_table[i].vel[k]) / pr;
          if (nb.lo[k] < obj_table[i].lo[k]) obj_table[i].lo[k] = nb.lo[k];
          if (nb.up[k] > obj_table[i].up[k]) obj_table[i].up[k] = nb.up[k];
        end
        for (int k = 0; k < 3; k++)
          obj_table[i].ch[k] += (nb.ch[k] - obj_table[i].ch[k]) / cr;
        r.object_slot = i[5:0];
        r.outcome = OUT_MERGED;
        r.obj_ch0 = obj_table[i].ch[0][7:0];
        r.obj_ch1 = obj_table[i].ch[1][7:0];
        r.obj_ch2 = obj_table[i].ch[2][7:0];
        r.obj_lower_x = obj_table[i].lo[0][10:0];
        r.obj_lower_y = obj_table[i].lo[1][10:0];
        r.obj_upper_x = obj_table[i].up[0][10:0];
        r.obj_upper_y = obj_table[i].up[1][10:0];
        r.obj_vel_x = obj_table[i].vel[0][11:0];
        r.obj_vel_y = obj_table[i].vel[1][11:0];
        return r;
      end
    end
    if (obj_count < NUM_SLOTS) begin
      nb.vel[0] = 0; nb.vel[1] = 0;
      obj_table[obj_count] = nb;
      r.object_slot = obj_count[5:0];
      r.outcome = OUT_CREATED;
      r.obj_ch0 = b.blob_ch0; r.obj_ch1 = b.blob_ch1; r.obj_ch2 = b.blob_ch2;
      r.obj_lower_x = b.blob_lower_x; r.obj_lower_y = b.blob_lower_y;
      r.obj_upper_x = b.blob_upper_x; r.obj_upper_y = b.blob_upper_y;
      obj_count++;
    end else begin
      r.outcome = OUT_DROPPED;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // input beat taken at this rising edge
  always @(posedge clk) in_took <= rst_n && in_valid && !in_stall;

  // driver
  int drv_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap <= 0;
    end else if (!in_valid || in_took) begin
      // previous beat was taken (or nothing offered)
      if (in_took) begin
        expected_q = {expected_q, group_blob(in_data)};
        void'(blob_queue.pop_front());
      end
      if (drv_gap > 0 || driver_pause || blob_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (drv_gap > 0) drv_gap <= drv_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= blob_queue[0];
        drv_gap <= gap_len();
      end
    end
  end

  // receiver: stall pattern, with a requested long hold-off
  int rcv_gap;
  int hold_cnt;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_gap <= 0;
      hold_cnt <= 0;
    end else if (long_hold_req && hold_cnt == 0) begin
      hold_cnt <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_cnt == 1) begin
      hold_cnt <= long_hold_req ? 1 : 0;
      out_stall <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      rcv_gap <= gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result beat %p", out_data);
        end else begin
          case (expected_q[0].outcome)
            OUT_MERGED: merges_seen <= merges_seen + 1;
            OUT_CREATED: creates_seen <= creates_seen + 1;
            default: drops_seen <= drops_seen + 1;
          endcase
          if (out_data !== expected_q[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", expected_q[0], out_data);
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout, %0d results outstanding", expected_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (blob_queue.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POSITION_RATE: vel_rate = val & 31;
      CFG_COLOR_RATE: col_rate = val & 31;
      default: corner_thresh = val & 2047;
    endcase
  endtask

  function automatic in_beat_t rand_blob();
    in_beat_t b;
    b = in_beat_t'(93'({$urandom, $urandom, $urandom}));
    b.start_frame = ($urandom_range(0, 99) == 0);
    return b;
  endfunction

  // blob close to a given one, so scans hit merges
  function automatic in_beat_t near_blob(in_beat_t s);
    in_beat_t b;
    b = s;
    b.start_frame = 1'b0;
    b.blob_ch0 = 8'(int'(s.blob_ch0) + $urandom_range(0, 60) - 30);
    b.blob_ch1 = 8'(int'(s.blob_ch1) + $urandom_range(0, 60) - 30);
    b.blob_ch2 = 8'(int'(s.blob_ch2) + $urandom_range(0, 60) - 30);
    b.blob_lower_x = 11'(int'(s.blob_lower_x) + $urandom_range(0, 200) - 100);
    b.blob_lower_y = 11'(int'(s.blob_lower_y) + $urandom_range(0, 200) - 100);
    b.blob_upper_x = 11'(int'(s.blob_upper_x) + $urandom_range(0, 200) - 100);
    b.blob_upper_y = 11'(int'(s.blob_upper_y) + $urandom_range(0, 200) - 100);
    b.blob_vel_x = 12'($urandom);
    b.blob_vel_y = 12'($urandom);
    return b;
  endfunction

  task automatic random_phase(int count);
    in_beat_t seeds[8];
    in_beat_t b;
    for (int k = 0; k < 8; k++) seeds[k] = rand_blob();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) b = near_blob(seeds[$urandom_range(0, 7)]);
      else b = rand_blob();
      if ($urandom_range(0, 149) == 0) b.start_frame = 1'b1;
      blob_queue = {blob_queue, b};
    end
  endtask

  initial begin
    in_beat_t b;
    int rates[4] = '{1, 0, 20, 31};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_POSITION_RATE;
    cfg_data = '0;
    obj_count = 0;
    vel_rate = 3; col_rate = 9; corner_thresh = 50;
    mismatches = 0; results_seen = 0; idle_cycles = 0;
    merges_seen = 0; creates_seen = 0; drops_seen = 0;
    long_hold_req = 0; driver_pause = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, merge, new object, full table, zero rates
    b = '0; b.start_frame = 1'b1;
    blob_queue = {blob_queue, b};
    b = '1; b.start_frame = 1'b0;
    blob_queue = {blob_queue, b};
    b.blob_vel_x = -12'sd2047; b.blob_vel_y = 12'sd2047;
    blob_queue = {blob_queue, b};
    b.blob_ch0 = 8'd230; b.blob_lower_x = 11'd0;
    blob_queue = {blob_queue, b};
    b = '0; b.blob_ch1 = 8'd25; b.blob_upper_y = 11'd50; b.blob_vel_x = 12'sd100;
    blob_queue = {blob_queue, b};
    b.blob_ch1 = 8'd26;
    blob_queue = {blob_queue, b};
    wait_drained();

    // fill past capacity with distinct colors to hit drops
    for (int n = 0; n < NUM_SLOTS + 4; n++) begin
      b = '0;
      b.start_frame = (n == 0);
      b.blob_ch0 = 8'(n * 4);
      b.blob_ch1 = 8'(n * 30);
      blob_queue = {blob_queue, b};
    end
    wait_drained();

    write_cfg(CFG_POSITION_RATE, 0);
    write_cfg(CFG_COLOR_RATE, 0);
    write_cfg(CFG_POINT_THRESHOLD, 2047);
    random_phase(200);
    // receiver holds off while the sender keeps offering
    long_hold_req = 1;
    wait_drained();
    long_hold_req = 0;

    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_POSITION_RATE, rates[p % 4]);
      write_cfg(CFG_COLOR_RATE, rates[(p + 1) % 4]);
      write_cfg(CFG_POINT_THRESHOLD, p == 0 ? 0 : $urandom_range(0, 400));
      random_phase(NUM_RANDOM / 6);
      if (p == 2) begin
        // sender waits for every outstanding result
        while (blob_queue.size() > 100) @(posedge clk);
        driver_pause = 1;
        while (expected_q.size() != 0 || in_valid) @(posedge clk);
        driver_pause = 0;
      end
      wait_drained();
    end

    $display("covered %0d results: %0d merged, %0d created, %0d dropped",
             results_seen, merges_seen, creates_seen, drops_seen);
    $display("rate and threshold extremes exercised, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
